// ===== src/tds_average_to_ppm_assert.svh =====
// Assertion helpers for the averaging and conversion block.
`ifndef TDS_AVERAGE_TO_PPM_ASSERT_SVH
`define TDS_AVERAGE_TO_PPM_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define TDSAP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define TDSAP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tdsap_pkg.sv =====
package tdsap_pkg;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_AVG_DIV,
        ST_VM_MUL,
        ST_VOLT_DIV,
        ST_POLY_A,
        ST_POLY_Q,
        ST_POLY_W,
        ST_PPM_DIV,
        ST_FINISH
    } state_t;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_SAMPLE_COUNT = 2'd0;
    localparam cfg_index_t REG_VREF_MV      = 2'd1;
    localparam cfg_index_t REG_WATER_TEMP   = 2'd2;

    localparam int ACC_W     = 57;  // multiplier accumulator
    localparam int MPLIER_W  = 18;  // serial multiplier operand
    localparam int VQ_W      = 18;  // volts, unsigned Q2.16
    localparam int VQ_FRAC   = 16;
    localparam int GAIN_W    = 17;  // vref * 49
    localparam int DEN_W     = 17;  // divider divisor
    localparam int PPM_SHIFT = 32;
    localparam int PPM_NUM_W = 23;

    localparam logic [VQ_W-1:0]     VQ_MAX      = 18'h3FFFF;
    localparam logic [5:0]          VOLT_GAIN   = 6'd49;
    localparam logic [6:0]          DEN_GAIN    = 7'd78;
    localparam logic [7:0]          TEMP_OFFSET = 8'd250;
    localparam logic [16:0]         COEF_CUBE   = 17'd66710;
    localparam logic [16:0]         COEF_SQUARE = 17'd127930;
    localparam logic [18:0]         COEF_LIN    = 19'd428695;
    localparam logic [6:0]          PPM_SCALE   = 7'd100;

    // a = 66710*v - 127930*2^16 starts from the negative offset
    localparam logic [ACC_W-1:0] POLY_A_INIT =
        ~(ACC_W'(COEF_SQUARE) << VQ_FRAC) + ACC_W'(1);
    // q = a*v + 428695*2^32
    localparam logic [ACC_W-1:0] POLY_Q_INIT = ACC_W'(COEF_LIN) << PPM_SHIFT;

    localparam logic [11:0] AVG_OUT_MAX = 12'hFFF;
    localparam logic [15:0] TDS_OUT_MAX = 16'hFFFF;

endpackage

// ===== src/tdsap_mul.sv =====
module tdsap_mul #(
    parameter int AW = 57,
    parameter int BW = 18
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] mcand_in,
    input  logic [BW-1:0] mplier_in,
    input  logic [AW-1:0] acc_init,
    output logic          busy,
    output logic [AW-1:0] product
);

    logic [AW-1:0] mcand_reg;
    logic [AW-1:0] mcand_next;
    logic [AW-1:0] acc_reg;
    logic [AW-1:0] acc_next;
    logic [BW-1:0] mplier_reg;
    logic [BW-1:0] mplier_next;

    // runs until the multiplier bits are used up
    assign busy    = (mplier_reg != '0);
    assign product = acc_reg;

    always_comb
    begin
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            mcand_next  = mcand_in;
            acc_next    = acc_init;
            mplier_next = mplier_in;
        end
        else if (busy)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mplier_reg <= '0;
        end
        else
        begin
            mplier_reg <= mplier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

endmodule

// ===== src/tdsap_div.sv =====
module tdsap_div #(
    parameter int NW = 45,
    parameter int QW = 30,
    parameter int DW = 17,
    localparam int CNTW = $clog2(NW + 1)
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NW-1:0]   num_in,
    input  logic [DW-1:0]   den_in,
    input  logic [CNTW-1:0] iters_in,
    output logic            busy,
    output logic [QW-1:0]   quotient,
    output logic            overflow
);

    logic [NW-1:0]   num_reg;
    logic [NW-1:0]   num_next;
    logic [DW-1:0]   den_reg;
    logic [DW-1:0]   den_next;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   rem_next;
    logic [QW-1:0]   q_reg;
    logic [QW-1:0]   q_next;
    logic            ovf_reg;
    logic            ovf_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;
    assign overflow = ovf_reg;

    // restoring step, numerator enters MSB first
    assign trial = {rem_reg, num_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            num_next = num_in;
            den_next = den_in;
            rem_next = '0;
            q_next   = '0;
            ovf_next = 1'b0;
            cnt_next = iters_in;
        end
        else if (busy)
        begin
            num_next = num_reg << 1;
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            q_next   = {q_reg[QW-2:0], fits};
            ovf_next = ovf_reg | q_reg[QW-1];
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

endmodule

// ===== src/tds_average_to_ppm.sv =====
// Averages ADC samples and converts the mean to total dissolved solids. Each transfer on the
// input adds one sample to a running sum; once sample_count samples are in (zero counts as
// one, anything above MAX_SAMPLES as MAX_SAMPLES), one result carries the truncated mean and
// the dissolved solids in tenths of ppm, and the sum clears. A sample that does not complete
// a reading is taken without a stall. A completing sample holds in_stall high while one
// bit-serial restoring divider and one shift-add multiplier work through the conversion.
// A finished result sits in an output register, so a stalled output does not stop
// sampling until the next reading completes. Configuration writes are always ready.
`include "tds_average_to_ppm_assert.svh"

module tds_average_to_ppm #(
    parameter int MAX_SAMPLES = 64,
    parameter int ADC_BITS    = 12
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ADC_BITS-1:0]  adc_sample,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [11:0]          average_raw,
    output logic [15:0]          tds_tenths_ppm,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  tdsap_pkg::cfg_index_t cfg_index,
    input  logic [10:0]          cfg_data
);

    import tdsap_pkg::*;

    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int SW     = ADC_BITS + $clog2(MAX_SAMPLES);
    localparam int CMP_W  = ((CW > 7) ? CW : 7) + 1;
    localparam int NW     = ADC_BITS + GAIN_W + VQ_FRAC;
    localparam int QW     = VQ_W + ADC_BITS;
    localparam int DCW    = $clog2(NW + 1);
    localparam int AVG_XW = (ADC_BITS > 12) ? ADC_BITS : 12;

    state_t state_reg;
    state_t state_next;

    logic [6:0]          sample_count_reg;
    logic [10:0]         vref_reg;
    logic [9:0]          temp_reg;
    logic [SW-1:0]       sum_reg;
    logic [SW-1:0]       sum_next;
    logic [CW-1:0]       taken_reg;
    logic [CW-1:0]       taken_next;
    logic [ADC_BITS-1:0] avg_reg;
    logic [ADC_BITS-1:0] avg_next;
    logic [VQ_W-1:0]     vq_reg;
    logic [VQ_W-1:0]     vq_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [11:0]         average_reg;
    logic [11:0]         average_next;
    logic [15:0]         tds_reg;
    logic [15:0]         tds_next;

    logic                in_accept;
    logic [SW-1:0]       sum_total;
    logic [CMP_W-1:0]    count_total;
    logic [CMP_W-1:0]    n_eff;
    logic                reading_done;
    logic [GAIN_W-1:0]   volt_gain;
    logic [DEN_W-1:0]    volt_den;
    logic [VQ_W-1:0]     vq_now;
    logic [AVG_XW-1:0]   avg_x;

    logic                mul_start;
    logic [ACC_W-1:0]    mul_mcand;
    logic [MPLIER_W-1:0] mul_mplier;
    logic [ACC_W-1:0]    mul_init;
    logic                mul_busy;
    logic [ACC_W-1:0]    mul_product;

    logic                div_start;
    logic [NW-1:0]       div_num;
    logic [DEN_W-1:0]    div_den;
    logic [DCW-1:0]      div_iters;
    logic                div_busy;
    logic [QW-1:0]       div_q;
    logic                div_ovf;

    assign in_stall       = (state_reg != ST_IDLE);
    assign in_accept      = in_valid && !in_stall;
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign average_raw    = average_reg;
    assign tds_tenths_ppm = tds_reg;

    assign sum_total   = sum_reg + SW'(adc_sample);
    assign count_total = CMP_W'(taken_reg) + CMP_W'(1);

    always_comb
    begin
        if (sample_count_reg == '0)
        begin
            n_eff = CMP_W'(1);
        end
        else if (CMP_W'(sample_count_reg) > CMP_W'(MAX_SAMPLES))
        begin
            n_eff = CMP_W'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = CMP_W'(sample_count_reg);
        end
    end

    assign reading_done = (count_total >= n_eff);

    // vref * 49 and 78 * (250 + T)
    assign volt_gain = GAIN_W'(vref_reg) * GAIN_W'(VOLT_GAIN);
    assign volt_den  = DEN_W'(DEN_W'(temp_reg) + DEN_W'(TEMP_OFFSET)) * DEN_W'(DEN_GAIN);

    assign vq_now = div_ovf ? VQ_MAX : div_q[QW-1:ADC_BITS];
    assign avg_x  = AVG_XW'(avg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 7'd10;
            vref_reg         <= 11'd1180;
            temp_reg         <= 10'd180;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_data[6:0];
                REG_VREF_MV:      vref_reg         <= cfg_data;
                REG_WATER_TEMP:   temp_reg         <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        avg_next       = avg_reg;
        vq_next        = vq_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;
        tds_next       = tds_reg;
        mul_start      = 1'b0;
        mul_mcand      = '0;
        mul_mplier     = '0;
        mul_init       = '0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        div_iters      = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (reading_done)
                    begin
                        div_start  = 1'b1;
                        div_num    = NW'(sum_total) << (NW - SW);
                        div_den    = DEN_W'(count_total);
                        div_iters  = DCW'(SW);
                        sum_next   = '0;
                        taken_next = '0;
                        state_next = ST_AVG_DIV;
                    end
                    else
                    begin
                        sum_next   = sum_total;
                        taken_next = count_total[CW-1:0];
                    end
                end
            end
            ST_AVG_DIV:
            begin
                if (!div_busy)
                begin
                    avg_next   = div_q[ADC_BITS-1:0];
                    mul_start  = 1'b1;
                    mul_mcand  = ACC_W'(div_q[ADC_BITS-1:0]);
                    mul_mplier = MPLIER_W'(volt_gain);
                    state_next = ST_VM_MUL;
                end
            end
            ST_VM_MUL:
            begin
                if (!mul_busy)
                begin
                    div_start  = 1'b1;
                    div_num    = NW'(mul_product[ADC_BITS+GAIN_W-1:0]) << VQ_FRAC;
                    div_den    = volt_den;
                    div_iters  = DCW'(NW);
                    state_next = ST_VOLT_DIV;
                end
            end
            ST_VOLT_DIV:
            begin
                if (!div_busy)
                begin
                    vq_next    = vq_now;
                    mul_start  = 1'b1;
                    mul_mcand  = ACC_W'(COEF_CUBE);
                    mul_mplier = vq_now;
                    mul_init   = POLY_A_INIT;
                    state_next = ST_POLY_A;
                end
            end
            ST_POLY_A:
            begin
                if (!mul_busy)
                begin
                    mul_start  = 1'b1;
                    mul_mcand  = mul_product;
                    mul_mplier = vq_reg;
                    mul_init   = POLY_Q_INIT;
                    state_next = ST_POLY_Q;
                end
            end
            ST_POLY_Q:
            begin
                if (!mul_busy)
                begin
                    // q is positive here
                    mul_start  = 1'b1;
                    mul_mcand  = mul_product >> VQ_FRAC;
                    mul_mplier = vq_reg;
                    state_next = ST_POLY_W;
                end
            end
            ST_POLY_W:
            begin
                if (!mul_busy)
                begin
                    div_start  = 1'b1;
                    div_num    = NW'(mul_product[PPM_SHIFT+PPM_NUM_W-1:PPM_SHIFT])
                                 << (NW - PPM_NUM_W);
                    div_den    = DEN_W'(PPM_SCALE);
                    div_iters  = DCW'(PPM_NUM_W);
                    state_next = ST_PPM_DIV;
                end
            end
            ST_PPM_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    average_next   = (avg_x > AVG_XW'(AVG_OUT_MAX)) ? AVG_OUT_MAX
                                                                   : avg_x[11:0];
                    tds_next       = (|div_q[QW-1:16]) ? TDS_OUT_MAX : div_q[15:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg     <= avg_next;
        vq_reg      <= vq_next;
        average_reg <= average_next;
        tds_reg     <= tds_next;
    end

    tdsap_mul #(
        .AW (ACC_W),
        .BW (MPLIER_W)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mul_start),
        .mcand_in  (mul_mcand),
        .mplier_in (mul_mplier),
        .acc_init  (mul_init),
        .busy      (mul_busy),
        .product   (mul_product)
    );

    tdsap_div #(
        .NW (NW),
        .QW (QW),
        .DW (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num_in   (div_num),
        .den_in   (div_den),
        .iters_in (div_iters),
        .busy     (div_busy),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    `TDSAP_ASSERT_IMP(a_idle_units_quiet, state_reg == ST_IDLE, !mul_busy && !div_busy, "arithmetic unit busy while idle")
    `TDSAP_ASSERT_NXT(a_reading_clears, in_accept && reading_done, (sum_reg == '0) && (taken_reg == '0), "sum not cleared after reading")
    `TDSAP_ASSERT_IMP(a_load_from_finish, $rose(out_valid_reg), $past(state_reg) == ST_FINISH, "result loaded outside finish")
    `TDSAP_ASSERT_IMP(a_count_below_max, in_accept, CMP_W'(taken_reg) < CMP_W'(MAX_SAMPLES), "sample count reached limit without result")

endmodule

// ===== test/tb_tds_average_to_ppm.sv =====
module tb_tds_average_to_ppm;
    import tdsap_pkg::*;

    localparam cfg_index_t REG_UNUSED = 2'd3;
    localparam int MAX_READING_SAMPLES = 64;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES = 10;
    localparam int SAMPLES_PER_PHASE = 100;

    typedef struct packed
    {
        logic [11:0] average;
        logic [15:0] tds;
    } reading_t;

    typedef enum logic [1:0]
    {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [11:0] adc_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [11:0] average_raw;
    logic [15:0] tds_tenths_ppm;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_index_t cfg_index = REG_SAMPLE_COUNT;
    logic [10:0] cfg_data = '0;

    // register shadow, reset values
    logic [6:0] samples_per_reading = 7'd10;
    logic [10:0] vref_mv = 11'd1180;
    logic [9:0] water_temp = 10'd180;

    int running_sum = 0;
    int samples_held = 0;
    reading_t expected_readings[$];
    logic [11:0] pending_samples[$];
    int samples_queued = 0;
    int samples_accepted = 0;
    int readings_checked = 0;
    int error_count = 0;

    int burst_left = 0;
    int gap_left = 0;
    logic next_valid;

    stall_mode_t stall_mode = STALL_NONE;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_count = 0;
    logic next_stall;

    int idle_cycles = 0;

    int count_plan[RANDOM_PHASES] = '{4, 1, 64, 127, 0, 2, 7, 33, 16, 3};
    int vref_plan[RANDOM_PHASES] = '{1180, 1000, 1300, 2047, 0, 1100, 1250, 1024, 1199, 1300};
    int temp_plan[RANDOM_PHASES] = '{180, 0, 800, 1023, 500, 250, 799, 1, 400, 0};

    tds_average_to_ppm uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .adc_sample    (adc_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average_raw   (average_raw),
        .tds_tenths_ppm(tds_tenths_ppm),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [17:0] mean_to_volts(input logic [11:0] mean);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] vq;
        num = (64'(mean) * 64'(vref_mv) * 64'd49) << 16;
        den = (64'd78 * (64'd250 + 64'(water_temp))) << 12;
        vq = num / den;
        if (vq > 64'h3FFFF)
            vq = 64'h3FFFF;
        return vq[17:0];
    endfunction

    function automatic logic [15:0] volts_to_tds(input logic [17:0] vq);
        logic [63:0] v;
        logic [63:0] q;
        logic [63:0] r;
        v = 64'(vq);
        q = 64'd66710 * v * v + (64'd428695 << 32) - ((64'd127930 * v) << 16);
        r = (((q >> 16) * v) >> 32) / 64'd100;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    task automatic take_sample(input logic [11:0] sample);
        int n;
        int mean;
        reading_t r;
        n = samples_per_reading;
        if (n == 0)
            n = 1;
        if (n > MAX_READING_SAMPLES)
            n = MAX_READING_SAMPLES;
        running_sum += sample;
        samples_held++;
        if (samples_held >= n)
        begin
            mean = running_sum / samples_held;
            r.average = mean[11:0];
            r.tds = volts_to_tds(mean_to_volts(mean[11:0]));
            expected_readings.push_back(r);
            running_sum = 0;
            samples_held = 0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [10:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SAMPLE_COUNT: samples_per_reading = value[6:0];
            REG_VREF_MV:      vref_mv = value;
            REG_WATER_TEMP:   water_temp = value[9:0];
            default: ;
        endcase
    endtask

    // all samples in, all readings out, then let any conversion finish
    task automatic settle();
        while (samples_accepted != samples_queued || expected_readings.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_sample(input logic [11:0] sample);
        pending_samples.push_back(sample);
        samples_queued++;
    endtask

    function automatic logic [11:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 12'h000;
        if (sel == 1)
            return 12'hFFF;
        return 12'($urandom_range(0, 4095));
    endfunction

    // sender: bursts with gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            adc_sample <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                take_sample(adc_sample);
                samples_accepted++;
                next_valid = 1'b0;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    next_valid = 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    adc_sample <= pending_samples.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                                  : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60)
                                                                : $urandom_range(0, 2);
                    end
                end
            end
            in_valid <= next_valid;
        end
    end

    // receiver: check each transfer, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            cycle_count++;
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch($sformatf("unexpected reading avg=%0d tds=%0d",
                                              average_raw, tds_tenths_ppm));
                else
                begin
                    reading_t exp_r;
                    exp_r = expected_readings.pop_front();
                    if (average_raw !== exp_r.average)
                        report_mismatch($sformatf("reading %0d average_raw %0d, want %0d",
                                                  readings_checked, average_raw,
                                                  exp_r.average));
                    if (tds_tenths_ppm !== exp_r.tds)
                        report_mismatch($sformatf("reading %0d tds_tenths_ppm %0d, want %0d",
                                                  readings_checked, tds_tenths_ppm,
                                                  exp_r.tds));
                end
                readings_checked++;
            end

            next_stall = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (!hold_done && readings_checked >= 15)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                next_stall = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (stall_mode)
                    STALL_NONE:     next_stall = 1'b0;
                    STALL_LIGHT:    next_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    next_stall = ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: next_stall = cycle_count[2];
                    default:        next_stall = 1'b0;
                endcase
            end
            out_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int vref;
        int temp;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // one sample per reading, saturated volts at full scale
        settle();
        write_register(REG_SAMPLE_COUNT, 11'd1);
        write_register(REG_VREF_MV, 11'd2047);
        write_register(REG_WATER_TEMP, 11'd0);
        queue_sample(12'hFFF);
        queue_sample(12'h000);
        queue_sample(12'h001);
        queue_sample(12'h800);
        queue_sample(12'hAAA);
        queue_sample(12'h555);

        // zero count acts as one; unused index has no effect
        settle();
        write_register(REG_SAMPLE_COUNT, 11'd0);
        write_register(REG_VREF_MV, 11'd0);
        write_register(REG_WATER_TEMP, 11'd1023);
        write_register(REG_UNUSED, 11'h7FF);
        queue_sample(12'hFFF);
        queue_sample(12'd2000);

        // count lowered part way through a reading
        settle();
        write_register(REG_SAMPLE_COUNT, 11'd10);
        write_register(REG_VREF_MV, 11'd1180);
        write_register(REG_WATER_TEMP, 11'd180);
        repeat (5) queue_sample(12'hFFF);
        settle();
        write_register(REG_SAMPLE_COUNT, 11'd3);
        queue_sample(12'h000);
        settle();
        write_register(REG_SAMPLE_COUNT, 11'd2);
        queue_sample(12'd100);
        queue_sample(12'd101);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            n = (p == 5) ? $urandom_range(2, 20) : count_plan[p];
            vref = (p == 8) ? $urandom_range(0, 2047) : vref_plan[p];
            temp = (p == 8) ? $urandom_range(0, 1023) : temp_plan[p];
            settle();
            write_register(REG_SAMPLE_COUNT, 11'(n));
            write_register(REG_VREF_MV, 11'(vref));
            write_register(REG_WATER_TEMP, 11'(temp));
            repeat (SAMPLES_PER_PHASE) queue_sample(pick_sample());
        end

        settle();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
